/* design/crr_pkg.sv */
// ----------------------------------------------------------------------------
// Rail evaluator package
// Shared payload types and sizes for the Catmull-Rom rail evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crr_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int COORD_W       = 32;
    localparam int PROG_W        = 24;
    localparam int FRAC_W        = 16;
    localparam int INDEX_W       = 6;
    localparam int COUNT_W       = 7;
    // Accumulator width covers the largest Horner partial sum.
    localparam int ACC_W         = 40;
    localparam int PROD_W        = ACC_W + FRAC_W + 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic [INDEX_W-1:0]        node_index;
        logic signed [COORD_W-1:0] node_x;
        logic signed [COORD_W-1:0] node_y;
        logic signed [COORD_W-1:0] node_z;
        logic signed [PROG_W-1:0]  progress;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } t_result;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_node;

endpackage

`default_nettype wire

/* design/crr_mem.sv */
// ----------------------------------------------------------------------------
// Node memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crr_mem #(
    parameter int DEPTH = crr_pkg::MAX_NODES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire crr_pkg::t_node             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output crr_pkg::t_node                  o_rdata
);

    crr_pkg::t_node r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/crr_lane.sv */
// ----------------------------------------------------------------------------
// Coordinate lane
// Pipelined Horner evaluation of one Catmull-Rom coordinate with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crr_lane (
    input  wire logic                                 i_clk,
    input  wire logic signed [crr_pkg::COORD_W-1:0]   i_p0,
    input  wire logic signed [crr_pkg::COORD_W-1:0]   i_p1,
    input  wire logic signed [crr_pkg::COORD_W-1:0]   i_p2,
    input  wire logic signed [crr_pkg::COORD_W-1:0]   i_p3,
    input  wire logic [crr_pkg::FRAC_W-1:0]           i_t,
    output logic signed [crr_pkg::COORD_W-1:0]        o_pos
);

    localparam int AW = crr_pkg::ACC_W;
    localparam int PW = crr_pkg::PROD_W;
    localparam int FW = crr_pkg::FRAC_W;
    localparam int CW = crr_pkg::COORD_W;

    typedef logic signed [AW-1:0] t_acc;
    typedef logic signed [PW-1:0] t_prod;

    // Stage registers; the fraction and the remaining terms ride along.
    t_acc r_c1_1, r_c2_1, r_c3_1, r_p2x_1;
    t_acc r_c1_2, r_c2_2, r_p2x_2;
    t_acc r_c1_3, r_p2x_3, r_a1_3;
    t_acc r_c1_4, r_p2x_4;
    t_acc r_p2x_5, r_a2_5;
    t_acc r_p2x_6;
    t_prod r_m1_2, r_m2_4, r_m3_6;
    logic [FW-1:0] r_t1, r_t2, r_t3, r_t4, r_t5;

    t_acc  n_c1, n_c2, n_c3, n_p2x, n_a1, n_a2, n_fin, n_half;
    t_prod n_m1, n_m2, n_m3;
    logic signed [CW-1:0] n_pos;

    always_comb begin
        n_c1  = t_acc'(i_p2) - t_acc'(i_p0);
        n_c2  = (t_acc'(i_p0) <<< 1) - t_acc'(i_p1) * t_acc'(5)
                + (t_acc'(i_p2) <<< 2) - t_acc'(i_p3);
        n_c3  = t_acc'(i_p1) * t_acc'(3) - t_acc'(i_p2) * t_acc'(3)
                + t_acc'(i_p3) - t_acc'(i_p0);
        n_p2x = t_acc'(i_p1) <<< 1;

        n_m1  = t_prod'(r_c3_1) * t_prod'({1'b0, r_t1});
        n_a1  = t_acc'(r_m1_2 >>> FW) + r_c2_2;
        n_m2  = t_prod'(r_a1_3) * t_prod'({1'b0, r_t3});
        n_a2  = t_acc'(r_m2_4 >>> FW) + r_c1_4;
        n_m3  = t_prod'(r_a2_5) * t_prod'({1'b0, r_t5});
        n_fin = t_acc'(r_m3_6 >>> FW) + r_p2x_6;
        n_half = n_fin >>> 1;

        if (n_half > t_acc'({1'b0, {(CW-1){1'b1}}})) begin
            n_pos = {1'b0, {(CW-1){1'b1}}};
        end else if (n_half < -t_acc'({1'b0, 1'b1, {(CW-1){1'b0}}})) begin
            n_pos = {1'b1, {(CW-1){1'b0}}};
        end else begin
            n_pos = n_half[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1_1  <= n_c1;
        r_c2_1  <= n_c2;
        r_c3_1  <= n_c3;
        r_p2x_1 <= n_p2x;
        r_t1    <= i_t;

        r_m1_2  <= n_m1;
        r_c1_2  <= r_c1_1;
        r_c2_2  <= r_c2_1;
        r_p2x_2 <= r_p2x_1;
        r_t2    <= r_t1;

        r_a1_3  <= n_a1;
        r_c1_3  <= r_c1_2;
        r_p2x_3 <= r_p2x_2;
        r_t3    <= r_t2;

        r_m2_4  <= n_m2;
        r_c1_4  <= r_c1_3;
        r_p2x_4 <= r_p2x_3;
        r_t4    <= r_t3;

        r_a2_5  <= n_a2;
        r_p2x_5 <= r_p2x_4;
        r_t5    <= r_t4;

        r_m3_6  <= n_m3;
        r_p2x_6 <= r_p2x_5;

        o_pos   <= n_pos;
    end

endmodule

`default_nettype wire

/* design/catmull_rom_rail_evaluator.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom rail evaluator
// Node table plus a pipelined uniform Catmull-Rom evaluator for 3D rails.
// ----------------------------------------------------------------------------
// An evaluate transaction passes one table read stage, six lane stages and
// one output register before its result strobes.
// Throughput: one transaction per cycle; busy is never raised, the four node
// reads use four replicated table copies and each lane is fully pipelined.
// Reset clears the node count and the pipeline valid bits; table contents
// stay undefined until written. The result receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_rail_evaluator #(
    parameter int MAX_NODES = crr_pkg::MAX_NODES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire crr_pkg::t_in_item                 i_item,
    output logic                                   o_valid,
    output crr_pkg::t_result                       o_result,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [crr_pkg::COUNT_W-1:0]       i_cfg_data
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int CW    = (AW + 1 > 8) ? AW + 1 : 8;
    localparam int DEPTH = 8;
    localparam int FW    = crr_pkg::FRAC_W;
    localparam int PW    = crr_pkg::PROG_W;

    logic [crr_pkg::COUNT_W-1:0] r_node_count;
    logic [DEPTH-1:0]            r_vld;
    logic                        r_zero;
    logic [FW-1:0]               r_t;

    logic                        n_accept, n_we, n_eval;
    logic [CW-1:0]               n_cnt, n_last, n_pint, n_idx, n_slot;
    logic [CW-1:0]               n_a0, n_a1, n_a2, n_a3;
    logic                        n_zero, n_direct;
    logic [FW-1:0]               n_t;
    crr_pkg::t_node              n_wdata;
    crr_pkg::t_node              rd0, rd1, rd2, rd3;
    crr_pkg::t_node              p0, p1, p2, p3;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_accept = start && !busy;
        n_eval   = n_accept && (i_item.operation == crr_pkg::OP_EVAL);
        n_slot   = CW'(i_item.node_index);
        n_we     = n_accept && (i_item.operation == crr_pkg::OP_WRITE)
                   && (n_slot < CW'(MAX_NODES));
        n_wdata  = '{x: i_item.node_x, y: i_item.node_y, z: i_item.node_z};

        n_cnt = (CW'(r_node_count) > CW'(MAX_NODES)) ? CW'(MAX_NODES)
                                                     : CW'(r_node_count);
        n_last = n_cnt - CW'(1);
        n_pint = CW'(i_item.progress[PW-2:FW]);
        n_zero = (n_cnt == '0);

        n_direct = 1'b1;
        n_idx    = '0;
        n_t      = '0;
        if (n_zero || n_cnt == CW'(1) || i_item.progress[PW-1]
                || i_item.progress == '0) begin
            n_idx = '0;
        end else if (n_pint >= n_last) begin
            n_idx = n_last;
        end else begin
            n_direct = 1'b0;
            n_idx    = n_pint;
            n_t      = i_item.progress[FW-1:0];
        end

        // A direct pick reads one node four times at t = 0, giving that node.
        if (n_direct) begin
            n_a0 = n_idx;
            n_a1 = n_idx;
            n_a2 = n_idx;
            n_a3 = n_idx;
        end else begin
            n_a0 = (n_idx > '0) ? n_idx - CW'(1) : '0;
            n_a1 = n_idx;
            n_a2 = (n_idx + CW'(1) < n_last) ? n_idx + CW'(1) : n_last;
            n_a3 = (n_idx + CW'(2) < n_last) ? n_idx + CW'(2) : n_last;
        end

        p0 = r_zero ? '0 : rd0;
        p1 = r_zero ? '0 : rd1;
        p2 = r_zero ? '0 : rd2;
        p3 = r_zero ? '0 : rd3;
    end

    crr_mem #(.DEPTH(MAX_NODES)) u_mem0 (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_slot[AW-1:0]), .i_wdata(n_wdata),
        .i_raddr(n_a0[AW-1:0]), .o_rdata(rd0)
    );
    crr_mem #(.DEPTH(MAX_NODES)) u_mem1 (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_slot[AW-1:0]), .i_wdata(n_wdata),
        .i_raddr(n_a1[AW-1:0]), .o_rdata(rd1)
    );
    crr_mem #(.DEPTH(MAX_NODES)) u_mem2 (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_slot[AW-1:0]), .i_wdata(n_wdata),
        .i_raddr(n_a2[AW-1:0]), .o_rdata(rd2)
    );
    crr_mem #(.DEPTH(MAX_NODES)) u_mem3 (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_slot[AW-1:0]), .i_wdata(n_wdata),
        .i_raddr(n_a3[AW-1:0]), .o_rdata(rd3)
    );

    crr_lane u_lane_x (
        .i_clk(i_clk), .i_p0(p0.x), .i_p1(p1.x), .i_p2(p2.x), .i_p3(p3.x),
        .i_t(r_t), .o_pos(o_result.pos_x)
    );
    crr_lane u_lane_y (
        .i_clk(i_clk), .i_p0(p0.y), .i_p1(p1.y), .i_p2(p2.y), .i_p3(p3.y),
        .i_t(r_t), .o_pos(o_result.pos_y)
    );
    crr_lane u_lane_z (
        .i_clk(i_clk), .i_p0(p0.z), .i_p1(p1.z), .i_p2(p2.z), .i_p3(p3.z),
        .i_t(r_t), .o_pos(o_result.pos_z)
    );

    always_ff @(posedge i_clk) begin
        r_zero <= n_zero;
        r_t    <= n_t;
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_vld        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
            r_vld <= {r_vld[DEPTH-2:0], n_eval};
        end
    end

    assign o_valid = r_vld[DEPTH-1];

endmodule

`default_nettype wire
